[rtl/rob_pkg.sv]
package rob_pkg;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_MARK   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_COMMIT = 2'd3;

    // Result status carried in m_tuser
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    localparam int MAX_ENTRIES_DEF  = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int OP_W      = 2;
    localparam int DATA_W    = 32;
    localparam int TAG_W     = 5;
    localparam int CFG_W     = 6;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    // Bit positions in m_tdata
    localparam int OUT_ASSIGNED_LSB  = 0;
    localparam int OUT_COMMITTED_LSB = 5;
    localparam int OUT_TAG_READY     = 37;
    localparam int OUT_HAS_SPACE     = 38;
    localparam int OUT_HEAD_READY    = 39;

endpackage

[rtl/rob_ram.sv]
module rob_ram #(
    parameter int WIDTH = rob_pkg::PAYLOAD_BITS_DEF,
    parameter int DEPTH = rob_pkg::MAX_ENTRIES_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/reorder_buffer_core.sv]
// Circular reorder buffer, one operation per transfer on the s_ side and one result per
// operation on the m_ side, in order. s_tuser selects the operation: insert at the tail,
// mark a tagged entry ready (its payload is replaced), query a tagged entry, or commit the
// head. Refused requests (insert when full, commit when the head is not ready, mark ready on
// an invalid entry) change nothing and return status 1. A new operation is accepted each cycle
// while the result register drains; throughput is set by the single payload RAM write port
// and the per-entry valid/ready flops updated in one pass. The payload RAM is read ahead at
// the next head position, with a write bypass. cfg_data sets the number of entries in use;
// the user must write it only while the buffer is idle, as the block does not enforce it.
module reorder_buffer_core #(
    parameter int MAX_ENTRIES  = rob_pkg::MAX_ENTRIES_DEF,
    parameter int PAYLOAD_BITS = rob_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rob_pkg::IN_TDATA_W-1:0]     s_tdata,  // payload[31:0], tag[36:32], zero
    input  logic [rob_pkg::OP_W-1:0]           s_tuser,  // operation[1:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rob_pkg::OUT_TDATA_W-1:0]    m_tdata,  // assigned_index[4:0],
                                                         // committed_payload[36:5],
                                                         // tag_ready[37], has_space[38],
                                                         // head_ready[39]
    output logic                               m_tuser,  // status[0]
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rob_pkg::CFG_W-1:0]          cfg_data
);

    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int STORE_W = (PAYLOAD_BITS < rob_pkg::DATA_W) ? PAYLOAD_BITS : rob_pkg::DATA_W;

    logic [rob_pkg::CFG_W-1:0] size_cfg_reg;
    logic [MAX_ENTRIES-1:0]    valid_reg, valid_next;
    logic [MAX_ENTRIES-1:0]    ready_reg, ready_next;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;

    logic                          out_valid_reg;
    logic [rob_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                          out_user_reg, out_user_next;

    logic                 byp_reg;
    logic [STORE_W-1:0]   byp_data_reg;
    logic [STORE_W-1:0]   ram_rd_data;
    logic [STORE_W-1:0]   head_payload;

    logic                 accept;
    logic [rob_pkg::DATA_W-1:0] in_payload;
    logic [rob_pkg::TAG_W-1:0]  in_tag;
    logic [IDX_W-1:0]     tag_idx;
    logic                 tag_in_range;
    logic                 tag_below_size;
    logic [31:0]          size_full;
    logic [IDX_W-1:0]     last_idx;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;

    assign accept       = s_tvalid && s_tready;
    assign s_tready     = !out_valid_reg || m_tready;
    assign cfg_ready    = 1'b1;
    assign in_payload   = s_tdata[31:0];
    assign in_tag       = s_tdata[36:32];
    assign tag_idx      = IDX_W'(in_tag);
    assign tag_in_range = 32'(in_tag) < 32'(MAX_ENTRIES);

    // Clamp the configured size into 1..MAX_ENTRIES
    always_comb
    begin
        priority if (size_cfg_reg == '0)
        begin
            size_full = 32'd1;
        end
        else if (32'(size_cfg_reg) > 32'(MAX_ENTRIES))
        begin
            size_full = 32'(MAX_ENTRIES);
        end
        else
        begin
            size_full = 32'(size_cfg_reg);
        end
    end

    assign last_idx       = IDX_W'(size_full - 32'd1);
    assign tag_below_size = 32'(in_tag) < size_full;
    assign head_payload   = byp_reg ? byp_data_reg : ram_rd_data;

    always_comb
    begin
        valid_next    = valid_reg;
        ready_next    = ready_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        wr_en         = 1'b0;
        wr_addr       = tail_reg;
        out_user_next = rob_pkg::STATUS_DONE;
        out_data_next = '0;
        if (accept)
        begin
            unique case (s_tuser)
                rob_pkg::OP_INSERT:
                begin
                    if (valid_reg[tail_reg])
                    begin
                        out_user_next = rob_pkg::STATUS_REFUSED;
                    end
                    else
                    begin
                        wr_en               = 1'b1;
                        wr_addr             = tail_reg;
                        valid_next[tail_reg] = 1'b1;
                        tail_next = (tail_reg < last_idx) ? tail_reg + 1'b1 : '0;
                        out_data_next[rob_pkg::OUT_ASSIGNED_LSB +: rob_pkg::TAG_W] =
                            rob_pkg::TAG_W'(tail_reg);
                    end
                end
                rob_pkg::OP_MARK:
                begin
                    if (tag_in_range && valid_reg[tag_idx])
                    begin
                        wr_en               = 1'b1;
                        wr_addr             = tag_idx;
                        ready_next[tag_idx] = 1'b1;
                    end
                    else
                    begin
                        out_user_next = rob_pkg::STATUS_REFUSED;
                    end
                end
                rob_pkg::OP_QUERY:
                begin
                    out_data_next[rob_pkg::OUT_TAG_READY] = tag_in_range && tag_below_size &&
                        valid_reg[tag_idx] && ready_reg[tag_idx];
                end
                rob_pkg::OP_COMMIT:
                begin
                    if (valid_reg[head_reg] && ready_reg[head_reg])
                    begin
                        valid_next[head_reg] = 1'b0;
                        ready_next[head_reg] = 1'b0;
                        head_next = (head_reg < last_idx) ? head_reg + 1'b1 : '0;
                        out_data_next[rob_pkg::OUT_COMMITTED_LSB +: rob_pkg::DATA_W] =
                            rob_pkg::DATA_W'(head_payload);
                    end
                    else
                    begin
                        out_user_next = rob_pkg::STATUS_REFUSED;
                    end
                end
                default:
                begin
                    out_user_next = rob_pkg::STATUS_REFUSED;
                end
            endcase
        end
        out_data_next[rob_pkg::OUT_HAS_SPACE]  = !valid_next[tail_next];
        out_data_next[rob_pkg::OUT_HEAD_READY] = valid_next[head_next] && ready_next[head_next];
    end

    rob_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_payload[STORE_W-1:0]),
        .rd_addr (head_next),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg  <= rob_pkg::CFG_RESET;
            valid_reg     <= '0;
            ready_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                size_cfg_reg <= cfg_data;
            end
            valid_reg <= valid_next;
            ready_reg <= ready_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            // Forward a write that lands on the entry being read ahead
            byp_reg   <= wr_en && (wr_addr == head_next);
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= in_payload[STORE_W-1:0];
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

[rtl/rob_checker.sv]
module rob_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [rob_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic [rob_pkg::OP_W-1:0]        s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rob_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [rob_pkg::CFG_W-1:0]       cfg_data
);

    // Every accepted operation shows its result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted operation produced no result");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

    // A query is never refused
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == rob_pkg::OP_QUERY)
        |=> (m_tuser == rob_pkg::STATUS_DONE))
    else $error("query refused");

    // Only a commit returns a payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser != rob_pkg::OP_COMMIT)
        |=> (m_tdata[rob_pkg::OUT_COMMITTED_LSB +: rob_pkg::DATA_W] == '0))
    else $error("payload returned by a non-commit operation");

endmodule

bind reorder_buffer_core rob_checker u_rob_checker (.*);

[test/tb_reorder_buffer_core.sv]
module tb_reorder_buffer_core;

    import rob_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_OPS   = 100;

    typedef struct packed {
        logic             status;
        logic [TAG_W-1:0] assigned;
        logic [DATA_W-1:0] committed;
        logic             tag_ready;
        logic             has_space;
        logic             head_ready;
    } rob_result_t;

    // Shadow copy of the buffer: predicts each result and holds the ones still owed.
    class rob_shadow;
        logic [DATA_W-1:0] payload_mem [MAX_ENTRIES_DEF];
        bit                valid_q [MAX_ENTRIES_DEF];
        bit                ready_q [MAX_ENTRIES_DEF];
        logic [TAG_W-1:0]  head;
        logic [TAG_W-1:0]  tail;
        logic [CFG_W-1:0]  size_reg;
        rob_result_t       expected_results[$];
        int                mismatches;
        int                op_count [4];
        int                refused_count;

        function new();
            foreach (valid_q[i])
            begin
                valid_q[i] = 1'b0;
                ready_q[i] = 1'b0;
                payload_mem[i] = '0;
            end
            head = '0;
            tail = '0;
            size_reg = CFG_RESET;
            mismatches = 0;
            refused_count = 0;
            foreach (op_count[i])
                op_count[i] = 0;
        endfunction

        function void set_size(logic [CFG_W-1:0] v);
            size_reg = v;
        endfunction

        // Register value 0 acts as 1, anything past the store acts as the store size.
        function int span();
            if (size_reg == 0)
                return 1;
            if (int'(size_reg) > MAX_ENTRIES_DEF)
                return MAX_ENTRIES_DEF;
            return int'(size_reg);
        endfunction

        function logic [TAG_W-1:0] step_ptr(logic [TAG_W-1:0] p);
            if (int'(p) < span() - 1)
                return p + 1'b1;
            return '0;
        endfunction

        function void apply_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] data,
                               logic [TAG_W-1:0] tag);
            rob_result_t r;
            r = '0;
            r.status = STATUS_DONE;
            case (op)
                OP_INSERT:
                begin
                    if (valid_q[tail])
                        r.status = STATUS_REFUSED;
                    else
                    begin
                        payload_mem[tail] = data;
                        valid_q[tail] = 1'b1;
                        r.assigned = tail;
                        tail = step_ptr(tail);
                    end
                end
                OP_MARK:
                begin
                    if (valid_q[tag])
                    begin
                        ready_q[tag] = 1'b1;
                        payload_mem[tag] = data;
                    end
                    else
                        r.status = STATUS_REFUSED;
                end
                OP_QUERY:
                    r.tag_ready = (int'(tag) < span()) && valid_q[tag] && ready_q[tag];
                OP_COMMIT:
                begin
                    if (valid_q[head] && ready_q[head])
                    begin
                        r.committed = payload_mem[head];
                        valid_q[head] = 1'b0;
                        ready_q[head] = 1'b0;
                        head = step_ptr(head);
                    end
                    else
                        r.status = STATUS_REFUSED;
                end
            endcase
            r.has_space = !valid_q[tail];
            r.head_ready = valid_q[head] && ready_q[head];
            op_count[op]++;
            if (r.status == STATUS_REFUSED)
                refused_count++;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic status, logic [OUT_TDATA_W-1:0] tdata);
            rob_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing pending: status %0h, data %0h",
                       status, tdata);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", DATA_W'(want.status), DATA_W'(status));
            compare_field("assigned_index", DATA_W'(want.assigned),
                          DATA_W'(tdata[OUT_ASSIGNED_LSB +: TAG_W]));
            compare_field("committed_payload", want.committed,
                          tdata[OUT_COMMITTED_LSB +: DATA_W]);
            compare_field("tag_ready", DATA_W'(want.tag_ready),
                          DATA_W'(tdata[OUT_TAG_READY]));
            compare_field("has_space", DATA_W'(want.has_space),
                          DATA_W'(tdata[OUT_HAS_SPACE]));
            compare_field("head_ready", DATA_W'(want.head_ready),
                          DATA_W'(tdata[OUT_HEAD_READY]));
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;   // payload[31:0], tag[36:32], zero
    logic [OP_W-1:0]         s_tuser = OP_QUERY;   // operation[1:0]
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;  // assigned_index[4:0], committed_payload[36:5],
                                       // tag_ready[37], has_space[38], head_ready[39]
    logic                    m_tuser;  // status[0]
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data = '0;

    rob_shadow sb = new();
    bit        calm = 1'b0;
    int        hold_cycles = 0;
    int        cycle_count = 0;
    int        sizes [6];

    reorder_buffer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // Result side: random stall bursts, or one long hold when requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles - 1) @(posedge clk);
                hold_cycles = 0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] data,
                           logic [TAG_W-1:0] tag);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, tag, data};
        do @(posedge clk); while (!s_tready);
        sb.apply_op(op, data, tag);
    endtask

    // Mostly well-formed traffic: marks and queries aim at live entries or the head.
    task automatic send_random_op();
        logic [OP_W-1:0]  op;
        logic [TAG_W-1:0] tag;
        int               pick;
        int               live[$];
        pick = $urandom_range(0, 99);
        if (pick < 30)
            op = OP_INSERT;
        else if (pick < 60)
            op = OP_MARK;
        else if (pick < 75)
            op = OP_QUERY;
        else
            op = OP_COMMIT;
        for (int i = 0; i < MAX_ENTRIES_DEF; i++)
            if (sb.valid_q[i])
                live.push_back(i);
        pick = $urandom_range(0, 9);
        if (live.size() == 0 || pick < 2)
            tag = TAG_W'($urandom);
        else if (pick < 6)
            tag = sb.head;
        else
            tag = TAG_W'(live[$urandom_range(0, live.size() - 1)]);
        send_op(op, $urandom, tag);
    endtask

    task automatic write_size(logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_size(v);
    endtask

    // Drop valid, then drain every owed result.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        sizes = '{32, 63, 1, 33, 7, 16};
        sizes[5] = $urandom_range(2, 31);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two entries: empty, full, not-ready head, invalid marks, wrap of both pointers.
        write_size(6'd2);
        send_op(OP_COMMIT, 32'h0000_0000, 5'd0);
        send_op(OP_QUERY, 32'h0000_0000, 5'd0);
        send_op(OP_MARK, 32'h1234_5678, 5'd0);
        send_op(OP_INSERT, 32'h0000_0000, 5'd0);
        send_op(OP_INSERT, 32'hFFFF_FFFF, 5'd31);
        send_op(OP_INSERT, 32'hDEAD_BEEF, 5'd0);
        send_op(OP_COMMIT, 32'h0000_0000, 5'd0);
        send_op(OP_QUERY, 32'h0000_0000, 5'd0);
        send_op(OP_MARK, 32'hA5A5_A5A5, 5'd0);
        send_op(OP_QUERY, 32'hFFFF_FFFF, 5'd0);
        send_op(OP_QUERY, 32'h0000_0000, 5'd31);
        send_op(OP_COMMIT, 32'h0000_0000, 5'd0);
        send_op(OP_MARK, 32'hFFFF_FFFF, 5'd1);
        send_op(OP_COMMIT, 32'hFFFF_FFFF, 5'd31);
        send_op(OP_INSERT, 32'h5A5A_5A5A, 5'd0);
        send_op(OP_MARK, 32'h0000_0000, 5'd31);
        send_op(OP_MARK, 32'h0000_0000, 5'd0);
        send_op(OP_COMMIT, 32'h0000_0000, 5'd0);
        settle();

        // Register zero acts as one entry; pointers left at one wrap on their next advance.
        write_size(6'd0);
        send_op(OP_INSERT, 32'h8000_0001, 5'd0);
        send_op(OP_MARK, 32'h7FFF_FFFE, 5'd1);
        send_op(OP_QUERY, 32'h0000_0000, 5'd1);
        send_op(OP_COMMIT, 32'h0000_0000, 5'd0);
        settle();

        foreach (sizes[p])
        begin
            write_size(CFG_W'(sizes[p]));
            if (p == 0)
                hold_cycles = 80;
            if (p == $size(sizes) - 1)
                calm = 1'b1;
            repeat (PHASE_OPS) send_random_op();
            settle();
        end
        repeat (8) @(posedge clk);

        $display("Ran %0d inserts, %0d marks, %0d queries, %0d commits; %0d refused",
                 sb.op_count[OP_INSERT], sb.op_count[OP_MARK], sb.op_count[OP_QUERY],
                 sb.op_count[OP_COMMIT], sb.refused_count);
        $display("Entry settings 2, 0, 32, 63, 1, 33, 7, %0d with one long output stall",
                 sizes[5]);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
